/* rtl/frame_energy_zcr_classifier_unit_defines.svh */
// Assertion macros shared by the classifier RTL.
// Needs signals named clock and reset in the module that expands them.
`ifndef FRAME_ENERGY_ZCR_CLASSIFIER_UNIT_DEFINES_SVH
`define FRAME_ENERGY_ZCR_CLASSIFIER_UNIT_DEFINES_SVH

// condition must hold at every edge out of reset
`define FEZC_ASSERT_HOLDS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FEZC_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/fezc_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// frame energy / zero-crossing classifier. No dependencies.
`timescale 1ns / 1ps

package fezc_pkg;

   localparam int FRAME_LEN = 300;

   localparam int SAMPLE_W   = 16;
   localparam int DC_W       = 24;
   localparam int PEAK_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int THR_W      = 10;
   localparam int CNT_W      = 10;
   localparam int FSUM_W     = 42;
   localparam int TSUM_W     = 58;
   localparam int TCROSS_W   = 26;
   localparam int FRAMES_W   = 16;
   localparam int ENERGY_W   = 32;
   localparam int MAG_W      = 24;
   localparam int PROD_W     = MAG_W + SCALE_W;
   localparam int QNORM_W    = 24;
   localparam int SQ_W       = 2 * QNORM_W;
   localparam int SQ_SHIFT   = 16;

   // shared restoring divider, two quotient bits per cycle
   localparam int DIVIDEND_W     = TSUM_W;
   localparam int DIVISOR_W      = 16;
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS      = DIVIDEND_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_PEAK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_SCALE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZCR_THR   = 2'd3;

   localparam logic [DC_W-1:0]    DC_RESET    = 24'd0;
   localparam logic [PEAK_W-1:0]  PEAK_RESET  = 16'd32767;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd5000;
   localparam logic [THR_W-1:0]   THR_RESET   = 10'd25;

   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_SEL_NORM  = 2'd0;
   localparam div_sel_type DIV_SEL_FRAME = 2'd1;
   localparam div_sel_type DIV_SEL_AVG   = 2'd2;

   typedef struct packed {
      logic        load;
      logic        mul;
      logic        div_start;
      div_sel_type div_sel;
      logic        sqr;
      logic        acc;
      logic        put_report;
      logic        put_decision;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic frame_full;
      logic last;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/frame_energy_zcr_classifier_unit.sv */
// Top level of the frame energy / zero-crossing word classifier.
// Depends on fezc_pkg, fezc_ctrl and fezc_dp.
`timescale 1ns / 1ps

// Samples are taken one at a time; the block takes no new sample until it is
// through with the last one. Most of that work is the shared divider, which
// produces two quotient bits per cycle over a 58-bit dividend (29 steps) for
// the amplitude normalization. A sample that completes a frame, or that
// carries last, also makes a second pass through the same divider for the
// frame mean; last adds a third pass for the run average before the decision.
// A finished result waits in an output register, so the next sample is taken
// while it is still stalled; only a second result that finds that register
// still occupied holds the block.
// Configuration writes take effect at once and are meant for idle periods.
module frame_energy_zcr_classifier_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fezc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_kind,
   output logic [fezc_pkg::FRAMES_W-1:0]        rsp_frame_number,
   output logic [fezc_pkg::ENERGY_W-1:0]        rsp_frame_energy,
   output logic [fezc_pkg::CNT_W-1:0]           rsp_frame_zcr,
   output logic [fezc_pkg::ENERGY_W-1:0]        rsp_average_energy,
   output logic                                 rsp_is_yes,
   output logic                                 rsp_end_of_run,
   input  logic                                 csr_we,
   input  logic [fezc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fezc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   fezc_pkg::ctrl_cmd_type  cmd;
   fezc_pkg::dp_status_type sts;

   fezc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fezc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_frame_energy   (rsp_frame_energy),
      .rsp_frame_zcr      (rsp_frame_zcr),
      .rsp_average_energy (rsp_average_energy),
      .rsp_is_yes         (rsp_is_yes),
      .rsp_end_of_run     (rsp_end_of_run)
   );

endmodule

/* rtl/fezc_div.sv */
// Shared serial restoring divider, two quotient bits per cycle.
// Depends on fezc_pkg for widths and step count.
`timescale 1ns / 1ps

module fezc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fezc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [fezc_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              done,
   output logic [fezc_pkg::DIVIDEND_W-1:0]   quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [fezc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [fezc_pkg::DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [fezc_pkg::DIVISOR_W-1:0]     dsr_ff, dsr_in;
   logic [fezc_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;

   logic [fezc_pkg::DIVISOR_W:0]       trial    [fezc_pkg::DIV_RADIX_BITS];
   logic [fezc_pkg::DIVISOR_W-1:0]     part_rem [fezc_pkg::DIV_RADIX_BITS+1];
   logic [fezc_pkg::DIVIDEND_W-1:0]    part_quo [fezc_pkg::DIV_RADIX_BITS+1];

   // quotient bits shift in at the bottom while dividend bits leave the top
   always_comb begin
      part_rem[0] = rem_ff;
      part_quo[0] = quo_ff;
      for (int i = 0; i < fezc_pkg::DIV_RADIX_BITS; i++) begin
         trial[i] = {part_rem[i], part_quo[i][fezc_pkg::DIVIDEND_W-1]};
         if (trial[i] >= {1'b0, dsr_ff}) begin
            part_rem[i+1] = fezc_pkg::DIVISOR_W'(trial[i] - {1'b0, dsr_ff});
            part_quo[i+1] = {part_quo[i][fezc_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            part_rem[i+1] = trial[i][fezc_pkg::DIVISOR_W-1:0];
            part_quo[i+1] = {part_quo[i][fezc_pkg::DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = part_rem[fezc_pkg::DIV_RADIX_BITS];
         quo_in = part_quo[fezc_pkg::DIV_RADIX_BITS];
         cnt_in = cnt_ff + fezc_pkg::DIV_CNT_W'(1);
         if (cnt_ff == fezc_pkg::DIV_CNT_W'(fezc_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/fezc_dp.sv */
// Datapath: config registers, sample energy, frame/run accumulators and the
// result register. Depends on fezc_pkg and fezc_div.
`timescale 1ns / 1ps

module fezc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  fezc_pkg::ctrl_cmd_type              cmd,
   output fezc_pkg::dp_status_type             sts,
   input  logic signed [fezc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last,
   input  logic                                csr_we,
   input  logic [fezc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fezc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [fezc_pkg::FRAMES_W-1:0]       rsp_frame_number,
   output logic [fezc_pkg::ENERGY_W-1:0]       rsp_frame_energy,
   output logic [fezc_pkg::CNT_W-1:0]          rsp_frame_zcr,
   output logic [fezc_pkg::ENERGY_W-1:0]       rsp_average_energy,
   output logic                                rsp_is_yes,
   output logic                                rsp_end_of_run
);

   // configuration
   logic [fezc_pkg::DC_W-1:0]     dc_ff, dc_in;
   logic [fezc_pkg::PEAK_W-1:0]   peak_ff, peak_in;
   logic [fezc_pkg::SCALE_W-1:0]  scale_ff, scale_in;
   logic [fezc_pkg::THR_W-1:0]    thr_ff, thr_in;

   // run state
   logic [fezc_pkg::CNT_W-1:0]    samples_ff, samples_in;
   logic [fezc_pkg::FSUM_W-1:0]   fsum_ff, fsum_in;
   logic [fezc_pkg::CNT_W-1:0]    fcross_ff, fcross_in;
   logic [fezc_pkg::TSUM_W-1:0]   total_ff, total_in;
   logic [fezc_pkg::TCROSS_W-1:0] tcross_ff, tcross_in;
   logic [fezc_pkg::FRAMES_W-1:0] frames_ff, frames_in;
   logic [fezc_pkg::SAMPLE_W-1:0] prev_ff, prev_in;

   // per-sample working registers
   logic                          last_ff, last_in;
   logic [fezc_pkg::MAG_W-1:0]    mag_ff, mag_in;
   logic [fezc_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [fezc_pkg::ENERGY_W-1:0] energy_ff, energy_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          kind_ff, kind_in;
   logic [fezc_pkg::FRAMES_W-1:0] fnum_ff, fnum_in;
   logic [fezc_pkg::ENERGY_W-1:0] fenergy_ff, fenergy_in;
   logic [fezc_pkg::CNT_W-1:0]    fzcr_ff, fzcr_in;
   logic [fezc_pkg::ENERGY_W-1:0] avg_ff, avg_in;
   logic                          yes_ff, yes_in;
   logic                          eor_ff, eor_in;

   logic [fezc_pkg::DC_W:0]            diff_w;
   logic                               cross_w;
   logic [fezc_pkg::DIVIDEND_W-1:0]    div_dividend;
   logic [fezc_pkg::DIVISOR_W-1:0]     div_divisor;
   logic                               div_done;
   logic [fezc_pkg::DIVIDEND_W-1:0]    div_quo;
   logic                               q_sat;
   logic [fezc_pkg::SQ_W-1:0]          sq_w;
   logic [fezc_pkg::FRAMES_W-1:0]      frames_next;
   logic [fezc_pkg::TCROSS_W-1:0]      thr_frames;
   logic                               out_free;

   fezc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      case (cmd.div_sel)
         fezc_pkg::DIV_SEL_NORM: begin
            div_dividend = fezc_pkg::DIVIDEND_W'(prod_ff);
            div_divisor  = (peak_ff == '0) ? fezc_pkg::DIVISOR_W'(1) : peak_ff;
         end
         fezc_pkg::DIV_SEL_FRAME: begin
            div_dividend = fezc_pkg::DIVIDEND_W'(fsum_ff);
            div_divisor  = fezc_pkg::DIVISOR_W'(samples_ff);
         end
         fezc_pkg::DIV_SEL_AVG: begin
            div_dividend = total_ff;
            div_divisor  = frames_ff;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = fezc_pkg::DIVISOR_W'(1);
         end
      endcase
   end

   // sample in Q8 minus the offset; magnitude fits 24 bits for all inputs
   assign diff_w = {req_sample[fezc_pkg::SAMPLE_W-1], req_sample, 8'b0}
                 - {dc_ff[fezc_pkg::DC_W-1], dc_ff};

   // strict sign change against the previous raw sample
   assign cross_w = (prev_ff[fezc_pkg::SAMPLE_W-1] && !req_sample[fezc_pkg::SAMPLE_W-1]
                     && (req_sample != '0))
                  || (!prev_ff[fezc_pkg::SAMPLE_W-1] && (prev_ff != '0)
                     && req_sample[fezc_pkg::SAMPLE_W-1]);

   assign q_sat       = |div_quo[fezc_pkg::DIVIDEND_W-1:fezc_pkg::QNORM_W];
   assign sq_w        = fezc_pkg::SQ_W'(div_quo[fezc_pkg::QNORM_W-1:0])
                      * fezc_pkg::SQ_W'(div_quo[fezc_pkg::QNORM_W-1:0]);
   assign frames_next = (frames_ff == '1) ? frames_ff
                                          : frames_ff + fezc_pkg::FRAMES_W'(1);
   assign thr_frames  = fezc_pkg::TCROSS_W'(thr_ff) * fezc_pkg::TCROSS_W'(frames_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      dc_in      = dc_ff;
      peak_in    = peak_ff;
      scale_in   = scale_ff;
      thr_in     = thr_ff;
      samples_in = samples_ff;
      fsum_in    = fsum_ff;
      fcross_in  = fcross_ff;
      total_in   = total_ff;
      tcross_in  = tcross_ff;
      frames_in  = frames_ff;
      prev_in    = prev_ff;
      last_in    = last_ff;
      mag_in     = mag_ff;
      prod_in    = prod_ff;
      energy_in  = energy_ff;
      kind_in    = kind_ff;
      fnum_in    = fnum_ff;
      fenergy_in = fenergy_ff;
      fzcr_in    = fzcr_ff;
      avg_in     = avg_ff;
      yes_in     = yes_ff;
      eor_in     = eor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_we) begin
         case (csr_index)
            fezc_pkg::CSR_DC_OFFSET: dc_in    = csr_wdata[fezc_pkg::DC_W-1:0];
            fezc_pkg::CSR_NORM_PEAK: peak_in  = csr_wdata[fezc_pkg::PEAK_W-1:0];
            fezc_pkg::CSR_AMP_SCALE: scale_in = csr_wdata[fezc_pkg::SCALE_W-1:0];
            fezc_pkg::CSR_ZCR_THR:   thr_in   = csr_wdata[fezc_pkg::THR_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         last_in = req_last;
         prev_in = req_sample;
         mag_in  = diff_w[fezc_pkg::DC_W] ? fezc_pkg::MAG_W'(-diff_w)
                                          : diff_w[fezc_pkg::MAG_W-1:0];
         if (cross_w) begin
            fcross_in = fcross_ff + fezc_pkg::CNT_W'(1);
            tcross_in = tcross_ff + fezc_pkg::TCROSS_W'(1);
         end
      end

      if (cmd.mul) begin
         prod_in = fezc_pkg::PROD_W'(mag_ff) * fezc_pkg::PROD_W'(scale_ff);
      end

      if (cmd.sqr) begin
         energy_in = q_sat ? '1 : sq_w[fezc_pkg::SQ_SHIFT +: fezc_pkg::ENERGY_W];
      end

      if (cmd.acc) begin
         fsum_in    = fsum_ff + fezc_pkg::FSUM_W'(energy_ff);
         total_in   = total_ff + fezc_pkg::TSUM_W'(energy_ff);
         samples_in = samples_ff + fezc_pkg::CNT_W'(1);
      end

      if (cmd.put_report) begin
         rsp_valid_in = 1'b1;
         kind_in      = 1'b0;
         fnum_in      = frames_next;
         fenergy_in   = div_quo[fezc_pkg::ENERGY_W-1:0];
         fzcr_in      = fcross_ff;
         avg_in       = '0;
         yes_in       = 1'b0;
         eor_in       = 1'b0;
         frames_in    = frames_next;
         samples_in   = '0;
         fsum_in      = '0;
         fcross_in    = '0;
      end

      if (cmd.put_decision) begin
         rsp_valid_in = 1'b1;
         kind_in      = 1'b1;
         fnum_in      = frames_ff;
         fenergy_in   = '0;
         fzcr_in      = '0;
         if (frames_ff == '0) begin
            avg_in = '0;
         end else if (|div_quo[fezc_pkg::DIVIDEND_W-1:fezc_pkg::ENERGY_W]) begin
            avg_in = '1;
         end else begin
            avg_in = div_quo[fezc_pkg::ENERGY_W-1:0];
         end
         yes_in     = (tcross_ff >= thr_frames);
         eor_in     = 1'b1;
         samples_in = '0;
         fsum_in    = '0;
         fcross_in  = '0;
         total_in   = '0;
         tcross_in  = '0;
         frames_in  = '0;
         prev_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff        <= fezc_pkg::DC_RESET;
         peak_ff      <= fezc_pkg::PEAK_RESET;
         scale_ff     <= fezc_pkg::SCALE_RESET;
         thr_ff       <= fezc_pkg::THR_RESET;
         samples_ff   <= '0;
         fsum_ff      <= '0;
         fcross_ff    <= '0;
         total_ff     <= '0;
         tcross_ff    <= '0;
         frames_ff    <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dc_ff        <= dc_in;
         peak_ff      <= peak_in;
         scale_ff     <= scale_in;
         thr_ff       <= thr_in;
         samples_ff   <= samples_in;
         fsum_ff      <= fsum_in;
         fcross_ff    <= fcross_in;
         total_ff     <= total_in;
         tcross_ff    <= tcross_in;
         frames_ff    <= frames_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff    <= last_in;
      mag_ff     <= mag_in;
      prod_ff    <= prod_in;
      energy_ff  <= energy_in;
      kind_ff    <= kind_in;
      fnum_ff    <= fnum_in;
      fenergy_ff <= fenergy_in;
      fzcr_ff    <= fzcr_in;
      avg_ff     <= avg_in;
      yes_ff     <= yes_in;
      eor_ff     <= eor_in;
   end

   assign sts.div_done   = div_done;
   assign sts.frame_full = (samples_ff >= fezc_pkg::CNT_W'(fezc_pkg::FRAME_LEN));
   assign sts.last       = last_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_frame_number   = fnum_ff;
   assign rsp_frame_energy   = fenergy_ff;
   assign rsp_frame_zcr      = fzcr_ff;
   assign rsp_average_energy = avg_ff;
   assign rsp_is_yes         = yes_ff;
   assign rsp_end_of_run     = eor_ff;

endmodule

/* rtl/fezc_ctrl.sv */
// Controller state machine: sequences one sample through the datapath and
// issues frame reports and the word decision. Depends on fezc_pkg and the defines header.
`timescale 1ns / 1ps
`include "frame_energy_zcr_classifier_unit_defines.svh"

module fezc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fezc_pkg::dp_status_type  sts,
   output fezc_pkg::ctrl_cmd_type   cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_NDIV  = 4'd2;
   localparam logic [3:0] ST_NWAIT = 4'd3;
   localparam logic [3:0] ST_SQR   = 4'd4;
   localparam logic [3:0] ST_ACC   = 4'd5;
   localparam logic [3:0] ST_CHK   = 4'd6;
   localparam logic [3:0] ST_RDIV  = 4'd7;
   localparam logic [3:0] ST_RWAIT = 4'd8;
   localparam logic [3:0] ST_RPUT  = 4'd9;
   localparam logic [3:0] ST_ADIV  = 4'd10;
   localparam logic [3:0] ST_AWAIT = 4'd11;
   localparam logic [3:0] ST_DPUT  = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.div_sel      = fezc_pkg::DIV_SEL_NORM;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_NDIV;
         end
         ST_NDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fezc_pkg::DIV_SEL_NORM;
            state_in      = ST_NWAIT;
         end
         ST_NWAIT: begin
            if (sts.div_done) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            cmd.sqr  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // a last sample always closes a frame (never empty here)
            state_in = (sts.frame_full || sts.last) ? ST_RDIV : ST_IDLE;
         end
         ST_RDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fezc_pkg::DIV_SEL_FRAME;
            state_in      = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (sts.div_done) begin
               state_in = ST_RPUT;
            end
         end
         ST_RPUT: begin
            if (sts.out_free) begin
               cmd.put_report = 1'b1;
               state_in       = sts.last ? ST_ADIV : ST_IDLE;
            end
         end
         ST_ADIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fezc_pkg::DIV_SEL_AVG;
            state_in      = ST_AWAIT;
         end
         ST_AWAIT: begin
            if (sts.div_done) begin
               state_in = ST_DPUT;
            end
         end
         ST_DPUT: begin
            if (sts.out_free) begin
               cmd.put_decision = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FEZC_ASSERT_HOLDS(a_cmd_exclusive,
      $onehot0({cmd.load, cmd.mul, cmd.div_start, cmd.sqr, cmd.acc, cmd.put_report,
                cmd.put_decision}),
      "more than one datapath command")
   `FEZC_ASSERT_IMPLIES(a_put_when_free, cmd.put_report || cmd.put_decision,
      sts.out_free, "result written over a pending transaction")
   `FEZC_ASSERT_IMPLIES(a_done_in_wait, sts.div_done,
      state_ff == ST_NWAIT || state_ff == ST_RWAIT || state_ff == ST_AWAIT,
      "divider finished outside a wait state")

endmodule

/* bench/frame_energy_zcr_classifier_unit_tb.sv */
// Self-checking bench for frame_energy_zcr_classifier_unit: drives sample
// transactions and register writes, predicts frame reports and word decisions.
// Depends on fezc_pkg and the classifier RTL.
`timescale 1ns / 1ps

localparam bit KIND_FRAME    = 1'b0;
localparam bit KIND_DECISION = 1'b1;

typedef struct packed {
   bit        kind;
   bit [15:0] frame_number;
   bit [31:0] frame_energy;
   bit [9:0]  frame_zcr;
   bit [31:0] average_energy;
   bit        is_yes;
   bit        end_of_run;
} classifier_result_type;

// Running frame statistics plus the queue of reports and decisions still owed.
class frame_stats_board;
   int unsigned           mismatches;
   classifier_result_type awaited[$];

   logic signed [23:0] dc_q8;
   logic [15:0]        peak_div;
   logic [15:0]        amp_scale;
   logic [9:0]         cross_thr;

   bit [9:0]           in_frame;
   bit [41:0]          frame_sum;
   bit [9:0]           frame_cross;
   bit [57:0]          word_energy;
   bit [25:0]          word_cross;
   bit [15:0]          frames;
   logic signed [15:0] prev_sample;

   function new();
      mismatches = 0;
      dc_q8      = fezc_pkg::DC_RESET;
      peak_div   = fezc_pkg::PEAK_RESET;
      amp_scale  = fezc_pkg::SCALE_RESET;
      cross_thr  = fezc_pkg::THR_RESET;
      clear_word();
   endfunction

   function void clear_word();
      in_frame    = '0;
      frame_sum   = '0;
      frame_cross = '0;
      word_energy = '0;
      word_cross  = '0;
      frames      = '0;
      prev_sample = '0;
   endfunction

   function void set_register(logic [1:0] idx, logic [23:0] data);
      case (idx)
         fezc_pkg::CSR_DC_OFFSET: dc_q8     = data;
         fezc_pkg::CSR_NORM_PEAK: peak_div  = data[15:0];
         fezc_pkg::CSR_AMP_SCALE: amp_scale = data[15:0];
         fezc_pkg::CSR_ZCR_THR:   cross_thr = data[9:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   function logic [31:0] scaled_energy(logic signed [15:0] s);
      longint            diff;
      longint unsigned   mag;
      longint unsigned   divisor;
      longint unsigned   q;
      longint unsigned   e;
      diff    = longint'(s) * 256 - longint'(dc_q8);
      mag     = (diff < 0) ? -diff : diff;
      divisor = (peak_div == 0) ? 64'd1 : 64'(peak_div);
      q       = mag * 64'(amp_scale) / divisor;
      if (q >= (64'd1 << 24))
         return '1;
      e = (q * q) >> 16;
      return (e > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
   endfunction

   function void close_frame();
      classifier_result_type r;
      r = '0;
      if (frames != 16'hFFFF)
         frames++;
      r.kind         = KIND_FRAME;
      r.frame_number = frames;
      r.frame_energy = 32'(frame_sum / in_frame);
      r.frame_zcr    = frame_cross;
      awaited.push_back(r);
      in_frame    = '0;
      frame_sum   = '0;
      frame_cross = '0;
   endfunction

   function void absorb_sample(logic signed [15:0] s, bit last);
      logic [31:0]           e;
      longint unsigned       avg;
      classifier_result_type r;
      if ((prev_sample < 0 && s > 0) || (prev_sample > 0 && s < 0)) begin
         frame_cross++;
         word_cross++;
      end
      prev_sample = s;
      e           = scaled_energy(s);
      frame_sum   = frame_sum + 42'(e);
      word_energy = word_energy + 58'(e);
      in_frame++;
      if (in_frame >= fezc_pkg::FRAME_LEN)
         close_frame();
      if (!last)
         return;
      if (in_frame > 0)
         close_frame();
      avg = (frames != 0) ? 64'(word_energy) / 64'(frames) : 64'd0;
      if (avg > 64'h0000_0000_FFFF_FFFF)
         avg = 64'h0000_0000_FFFF_FFFF;
      r                = '0;
      r.kind           = KIND_DECISION;
      r.frame_number   = frames;
      r.average_energy = avg[31:0];
      r.is_yes         = (64'(word_cross) >= 64'(cross_thr) * 64'(frames));
      r.end_of_run     = 1'b1;
      awaited.push_back(r);
      clear_word();
   endfunction

   task note_mismatch(string what);
      $display("%0t ns: MISMATCH %s", $realtime, what);
      mismatches++;
   endtask

   task check_field(string name, longint unsigned got, longint unsigned want);
      if (got != want)
         note_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   task compare_report(classifier_result_type got);
      classifier_result_type want;
      if (awaited.size() == 0) begin
         note_mismatch($sformatf("unexpected result transaction 0x%0h", got));
         return;
      end
      want = awaited.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("frame_number", got.frame_number, want.frame_number);
      check_field("frame_energy", got.frame_energy, want.frame_energy);
      check_field("frame_zcr", got.frame_zcr, want.frame_zcr);
      check_field("average_energy", got.average_energy, want.average_energy);
      check_field("is_yes", got.is_yes, want.is_yes);
      check_field("end_of_run", got.end_of_run, want.end_of_run);
   endtask
endclass

module frame_energy_zcr_classifier_unit_tb;

   localparam int RANDOM_ITEMS  = 900;
   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 4000;
   localparam int QUIET_LIMIT   = 20000;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   logic                                 req_stall;
   logic signed [fezc_pkg::SAMPLE_W-1:0] req_sample  = '0;
   logic                                 req_last    = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall   = 1'b0;
   logic                                 rsp_kind;
   logic [fezc_pkg::FRAMES_W-1:0]        rsp_frame_number;
   logic [fezc_pkg::ENERGY_W-1:0]        rsp_frame_energy;
   logic [fezc_pkg::CNT_W-1:0]           rsp_frame_zcr;
   logic [fezc_pkg::ENERGY_W-1:0]        rsp_average_energy;
   logic                                 rsp_is_yes;
   logic                                 rsp_end_of_run;
   logic                                 csr_we      = 1'b0;
   logic [fezc_pkg::CSR_IDX_W-1:0]       csr_index   = '0;
   logic [fezc_pkg::CSR_DATA_W-1:0]      csr_wdata   = '0;

   frame_stats_board board;
   int samples_taken = 0;
   int quiet_cycles  = 0;
   bit steady_word   = 1'b0;

   frame_energy_zcr_classifier_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_frame_number   (rsp_frame_number),
      .rsp_frame_energy   (rsp_frame_energy),
      .rsp_frame_zcr      (rsp_frame_zcr),
      .rsp_average_energy (rsp_average_energy),
      .rsp_is_yes         (rsp_is_yes),
      .rsp_end_of_run     (rsp_end_of_run),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 200);
   endfunction

   function automatic int pick_word_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 24);
      if (r < 90) return fezc_pkg::FRAME_LEN;
      if (r < 94)
         return ($urandom_range(0, 1) != 0) ? fezc_pkg::FRAME_LEN + 1
                                            : fezc_pkg::FRAME_LEN - 1;
      return $urandom_range(25, 650);
   endfunction

   function automatic logic signed [15:0] pick_sample(int style, int i);
      int mag;
      case (style)
         1: begin
            // alternating sign drives the crossing count up
            mag = $urandom_range(1, 32767);
            return (i % 2 != 0) ? 16'(-mag) : 16'(mag);
         end
         2: return 16'(int'($urandom_range(0, 6)) - 3);
         3: case ($urandom_range(0, 4))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sh0000;
               3: return 16'shFFFF;
               default: return 16'sh0001;
            endcase
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [15:0] s, input bit last);
      int gap;
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.absorb_sample(s, last);
      samples_taken++;
      gap = steady_word ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_word(input int len);
      int style;
      style       = $urandom_range(0, 3);
      steady_word = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(style, i), i == len - 1);
   endtask

   // wait for every owed result, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [23:0] dc, input logic [15:0] peak,
                                 input logic [15:0] scale, input logic [9:0] thr);
      logic [23:0] vals [4];
      logic [1:0]  idxs [4];
      vals = '{dc, 24'(peak), 24'(scale), 24'(thr)};
      idxs = '{fezc_pkg::CSR_DC_OFFSET, fezc_pkg::CSR_NORM_PEAK,
               fezc_pkg::CSR_AMP_SCALE, fezc_pkg::CSR_ZCR_THR};
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idxs[k];
         csr_wdata <= vals[k];
         @(posedge clock);
         board.set_register(idxs[k], vals[k]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_settings();
      logic [23:0] dc;
      logic [15:0] peak;
      logic [15:0] scale;
      logic [9:0]  thr;
      case ($urandom_range(0, 4))
         0: dc = 24'h800000;
         1: dc = 24'h7FFFFF;
         2: dc = '0;
         3: dc = 24'(int'($urandom_range(0, 8192)) - 4096);
         default: dc = 24'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: peak = '0;
         1: peak = 16'd1;
         2: peak = 16'd32768;
         3: peak = 16'($urandom);
         default: peak = 16'($urandom_range(1, 32768));
      endcase
      case ($urandom_range(0, 5))
         0: scale = '0;
         1: scale = 16'd1;
         2: scale = 16'hFFFF;
         3: scale = 16'd5000;
         default: scale = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: thr = '0;
         1: thr = 10'h3FF;
         2: thr = 10'($urandom_range(0, 40));
         default: thr = 10'($urandom);
      endcase
      apply_settings(dc, peak, scale, thr);
   endtask

   initial begin : stimulus
      int directed_count;
      int words;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: extremes and sign changes through zero
      send_sample(16'sd0, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd5, 1'b1);
      send_sample(16'sh8000, 1'b1);
      settle();

      // zero divisor and saturating energy/average
      apply_settings(24'h7FFFFF, 16'd0, 16'hFFFF, 10'd0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b1);
      settle();

      apply_settings(24'h800000, 16'd32768, 16'd1, 10'h3FF);
      send_sample(16'sd100, 1'b0);
      send_sample(-16'sd100, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      settle();

      directed_count = samples_taken;
      while (samples_taken - directed_count < RANDOM_ITEMS) begin
         random_settings();
         words = $urandom_range(2, 6);
         repeat (words) send_word(pick_word_len());
         settle();
      end

      if (board.pending() != 0)
         board.note_mismatch($sformatf("%0d results never arrived", board.pending()));
      if (board.mismatches == 0)
         $display("frame_energy_zcr_classifier_unit_tb OK");
      else
         $display("frame_energy_zcr_classifier_unit_tb NOT OK");
      $finish;
   end

   // result side back-pressure, with one long hold while samples keep coming
   initial begin : rsp_pacer
      bit pressure_done;
      int n;
      pressure_done = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!pressure_done && samples_taken >= 150 && req_valid) begin
            pressure_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(10, 80)) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      classifier_result_type observed;
      if (!reset && rsp_valid && !rsp_stall) begin
         observed = {rsp_kind, rsp_frame_number, rsp_frame_energy, rsp_frame_zcr,
                     rsp_average_energy, rsp_is_yes, rsp_end_of_run};
         board.compare_report(observed);
      end
   end

   // counts cycles without any transaction on either channel
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("frame_energy_zcr_classifier_unit_tb NOT OK");
         $finish;
      end
   end

endmodule
